FILE: rtl/core/tsci_pkg.sv
// Shared types, constants and helpers of the touch stroke calibration block.
package tsci_pkg;

	localparam int RAW_W   = 10;
	localparam int SIZE_W  = 11;
	localparam int COORD_W = 12;
	localparam int REG_W   = 11;
	localparam int IDX_W   = 3;
	localparam int STEP_W  = 3;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] REG_X_MIN  = 3'd0;
	localparam logic [IDX_W-1:0] REG_X_MAX  = 3'd1;
	localparam logic [IDX_W-1:0] REG_Y_MIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_Y_MAX  = 3'd3;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;
	localparam logic [IDX_W-1:0] REG_JITTER = 3'd6;

	// register reset values
	localparam logic [RAW_W-1:0]  RST_X_MIN  = 10'd190;
	localparam logic [RAW_W-1:0]  RST_X_MAX  = 10'd850;
	localparam logic [RAW_W-1:0]  RST_Y_MIN  = 10'd345;
	localparam logic [RAW_W-1:0]  RST_Y_MAX  = 10'd690;
	localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd480;
	localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd275;
	localparam logic [RAW_W-1:0]  RST_JITTER = 10'd5;

	localparam logic signed [COORD_W-1:0] SAT_MAX = 12'sh7FF;
	localparam logic signed [COORD_W-1:0] SAT_MIN = 12'sh800;

	// subdivision points in emission order
	localparam logic [STEP_W-1:0] PT_M  = 3'd0;
	localparam logic [STEP_W-1:0] PT_M1 = 3'd1;
	localparam logic [STEP_W-1:0] PT_M2 = 3'd2;
	localparam logic [STEP_W-1:0] PT_M3 = 3'd3;
	localparam logic [STEP_W-1:0] PT_M4 = 3'd4;
	localparam logic [STEP_W-1:0] PT_M5 = 3'd5;
	localparam logic [STEP_W-1:0] PT_M6 = 3'd6;

	typedef struct packed {
		logic             kind;
		logic [RAW_W-1:0] raw_x;
		logic [RAW_W-1:0] raw_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      last;
	} out_beat_t;

	typedef struct packed {
		logic              accept;
		logic              scale_start;
		logic              scale_prev;
		logic              store_b;
		logic              store_a;
		logic              emit_load;
		logic              emit_single;
		logic [STEP_W-1:0] emit_step;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic jump;
		logic scale_done;
		logic out_free;
	} sts_t;

	// (p+q)/2, truncated toward zero
	function automatic logic signed [COORD_W-1:0] half_sum(
		input logic signed [COORD_W-1:0] p,
		input logic signed [COORD_W-1:0] q
	);
		logic [COORD_W:0] s;
		logic [COORD_W:0] t;
		s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
		t = s + {{COORD_W{1'b0}}, s[COORD_W]};
		return $signed(t[COORD_W:1]);
	endfunction

endpackage

FILE: rtl/core/tsci_scale.sv
// One axis scaling lane: multiply, then restoring divide with saturation.
module tsci_scale (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [tsci_pkg::RAW_W-1:0]           raw,
	input  logic [tsci_pkg::RAW_W-1:0]           lo,
	input  logic [tsci_pkg::RAW_W-1:0]           hi,
	input  logic [tsci_pkg::SIZE_W-1:0]          size,
	output logic                                 done,
	output logic signed [tsci_pkg::COORD_W-1:0]  result
);
	import tsci_pkg::*;

	localparam int PROD_W = RAW_W + SIZE_W + 2;
	localparam int REM_W  = RAW_W + COORD_W;
	localparam int BIT_W  = $clog2(COORD_W);
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ABS  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;
	localparam logic [COORD_W-1:0] NEG_LIM = COORD_W'(1) << (COORD_W - 1);

	logic [1:0]               ph_q;
	logic [BIT_W-1:0]         bit_q;
	logic signed [RAW_W:0]    diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0]        prod_abs;
	logic [RAW_W-1:0]         den_q;
	logic                     empty_q;
	logic                     neg_q;
	logic                     ovf_q;
	logic [REM_W-1:0]         rem_q;
	logic [REM_W-1:0]         trial;
	logic [COORD_W-1:0]       quo_q;

	assign diff     = $signed({1'b0, raw}) - $signed({1'b0, lo});
	assign prod     = diff * $signed({1'b0, size});
	assign prod_abs = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign trial    = REM_W'(den_q) << bit_q;
	assign done     = (ph_q == PH_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_IDLE;
			bit_q <= '0;
		end else begin
			case (ph_q)
				PH_IDLE: begin
					if (start) ph_q <= PH_ABS;
				end
				PH_ABS: begin
					ph_q  <= PH_DIV;
					bit_q <= BIT_W'(COORD_W - 1);
				end
				PH_DIV: begin
					if (bit_q == '0) ph_q <= PH_DONE;
					else bit_q <= bit_q - 1'b1;
				end
				PH_DONE: ph_q <= PH_IDLE;
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PH_IDLE && start) begin
			prod_q  <= prod;
			den_q   <= hi - lo;
			empty_q <= (hi <= lo);
		end
		if (ph_q == PH_ABS) begin
			rem_q <= prod_abs[REM_W-1:0];
			neg_q <= prod_q[PROD_W-1];
			ovf_q <= (prod_abs[REM_W-1:0] >= {den_q, {COORD_W{1'b0}}});
			quo_q <= '0;
		end
		if (ph_q == PH_DIV && rem_q >= trial) begin
			rem_q        <= rem_q - trial;
			quo_q[bit_q] <= 1'b1;
		end
	end

	always_comb begin
		if (empty_q)
			result = '0;
		else if (!neg_q)
			result = (ovf_q || quo_q[COORD_W-1]) ? SAT_MAX : $signed(quo_q);
		else if (ovf_q || quo_q > NEG_LIM)
			result = SAT_MIN;
		else
			result = $signed(COORD_W'(-quo_q));
	end

endmodule

FILE: rtl/core/tsci_datapath.sv
// Datapath: registers, sample state, two scaling lanes, midpoints, output stage.
module tsci_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tsci_pkg::in_beat_t           sample,
	input  logic                         wr_en,
	input  logic [tsci_pkg::IDX_W-1:0]   wr_index,
	input  logic [tsci_pkg::REG_W-1:0]   wr_data,
	input  tsci_pkg::cmd_t               cmd,
	output tsci_pkg::sts_t               sts,
	output logic                         point_valid,
	input  logic                         point_ready,
	output tsci_pkg::out_beat_t          point
);
	import tsci_pkg::*;

	logic [RAW_W-1:0]  x_min_q, x_max_q, y_min_q, y_max_q, jitter_q;
	logic [SIZE_W-1:0] width_q, height_q;
	logic [RAW_W-1:0]  prev_x_q, prev_y_q;
	logic [RAW_W-1:0]  cur_x_q, cur_y_q, old_x_q, old_y_q;
	logic              kind_q, jump_q;
	logic [RAW_W-1:0]  dx, dy;
	logic [RAW_W-1:0]  lane_raw_x, lane_raw_y;
	logic              done_x, done_y;
	logic signed [COORD_W-1:0] res_x, res_y;
	logic signed [COORD_W-1:0] a_x_q, a_y_q, b_x_q, b_y_q;
	logic signed [COORD_W-1:0] m_x_q, m_y_q, m1_x_q, m1_y_q, m2_x_q, m2_y_q;
	logic signed [COORD_W-1:0] px, py, qx, qy, mid_x, mid_y;
	logic              out_valid_q;
	out_beat_t         out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= RST_X_MIN;
			x_max_q  <= RST_X_MAX;
			y_min_q  <= RST_Y_MIN;
			y_max_q  <= RST_Y_MAX;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			jitter_q <= RST_JITTER;
		end else if (wr_en) begin
			case (wr_index)
				REG_X_MIN:  x_min_q  <= wr_data[RAW_W-1:0];
				REG_X_MAX:  x_max_q  <= wr_data[RAW_W-1:0];
				REG_Y_MIN:  y_min_q  <= wr_data[RAW_W-1:0];
				REG_Y_MAX:  y_max_q  <= wr_data[RAW_W-1:0];
				REG_WIDTH:  width_q  <= wr_data[SIZE_W-1:0];
				REG_HEIGHT: height_q <= wr_data[SIZE_W-1:0];
				REG_JITTER: jitter_q <= wr_data[RAW_W-1:0];
				default: ;
			endcase
		end
	end

	assign dx = (sample.raw_x >= prev_x_q) ? sample.raw_x - prev_x_q : prev_x_q - sample.raw_x;
	assign dy = (sample.raw_y >= prev_y_q) ? sample.raw_y - prev_y_q : prev_y_q - sample.raw_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q <= '0;
			prev_y_q <= '0;
			kind_q   <= 1'b0;
			jump_q   <= 1'b0;
		end else if (cmd.accept) begin
			prev_x_q <= sample.raw_x;
			prev_y_q <= sample.raw_y;
			kind_q   <= sample.kind;
			jump_q   <= (dx > jitter_q) || (dy > jitter_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cur_x_q <= sample.raw_x;
			cur_y_q <= sample.raw_y;
			old_x_q <= prev_x_q;
			old_y_q <= prev_y_q;
		end
	end

	assign lane_raw_x = cmd.scale_prev ? old_x_q : cur_x_q;
	assign lane_raw_y = cmd.scale_prev ? old_y_q : cur_y_q;

	tsci_scale u_scale_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.scale_start),
		.raw    (lane_raw_x),
		.lo     (x_min_q),
		.hi     (x_max_q),
		.size   (width_q),
		.done   (done_x),
		.result (res_x)
	);

	tsci_scale u_scale_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.scale_start),
		.raw    (lane_raw_y),
		.lo     (y_min_q),
		.hi     (y_max_q),
		.size   (height_q),
		.done   (done_y),
		.result (res_y)
	);

	always_ff @(posedge clk) begin
		if (cmd.store_b) begin
			b_x_q <= res_x;
			b_y_q <= res_y;
		end
		if (cmd.store_a) begin
			a_x_q <= res_x;
			a_y_q <= res_y;
		end
	end

	// operand pair of the point being emitted
	always_comb begin
		px = b_x_q;  py = b_y_q;
		qx = a_x_q;  qy = a_y_q;
		case (cmd.emit_step)
			PT_M: begin
				px = b_x_q;  py = b_y_q;  qx = a_x_q;  qy = a_y_q;
			end
			PT_M1: begin
				px = m_x_q;  py = m_y_q;  qx = a_x_q;  qy = a_y_q;
			end
			PT_M2: begin
				px = m_x_q;  py = m_y_q;  qx = b_x_q;  qy = b_y_q;
			end
			PT_M3: begin
				px = a_x_q;  py = a_y_q;  qx = m1_x_q; qy = m1_y_q;
			end
			PT_M4: begin
				px = m_x_q;  py = m_y_q;  qx = m1_x_q; qy = m1_y_q;
			end
			PT_M5: begin
				px = m_x_q;  py = m_y_q;  qx = m2_x_q; qy = m2_y_q;
			end
			PT_M6: begin
				px = m2_x_q; py = m2_y_q; qx = b_x_q;  qy = b_y_q;
			end
			default: ;
		endcase
	end

	assign mid_x = half_sum(px, qx);
	assign mid_y = half_sum(py, qy);

	always_ff @(posedge clk) begin
		if (cmd.emit_load && !cmd.emit_single) begin
			if (cmd.emit_step == PT_M) begin
				m_x_q <= mid_x;
				m_y_q <= mid_y;
			end
			if (cmd.emit_step == PT_M1) begin
				m1_x_q <= mid_x;
				m1_y_q <= mid_y;
			end
			if (cmd.emit_step == PT_M2) begin
				m2_x_q <= mid_x;
				m2_y_q <= mid_y;
			end
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_load)
			out_valid_q <= 1'b1;
		else if (point_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_q.screen_x <= cmd.emit_single ? b_x_q : mid_x;
			out_q.screen_y <= cmd.emit_single ? b_y_q : mid_y;
			out_q.last     <= cmd.emit_single || (cmd.emit_step == PT_M6);
		end
	end

	assign point_valid    = out_valid_q;
	assign point          = out_q;
	assign sts.kind       = kind_q;
	assign sts.jump       = jump_q;
	assign sts.scale_done = done_x & done_y;
	assign sts.out_free   = !out_valid_q || point_ready;

endmodule

FILE: rtl/core/tsci_ctrl.sv
// Controller: sequences scaling of both samples and emission of points.
module tsci_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            sample_valid,
	output logic            sample_ready,
	input  tsci_pkg::sts_t  sts,
	output tsci_pkg::cmd_t  cmd
);
	import tsci_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_START_B = 3'd1;
	localparam logic [2:0] S_WAIT_B  = 3'd2;
	localparam logic [2:0] S_START_A = 3'd3;
	localparam logic [2:0] S_WAIT_A  = 3'd4;
	localparam logic [2:0] S_EMIT    = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              single_q, single_d;

	always_comb begin
		state_d      = state_q;
		step_d       = step_q;
		single_d     = single_q;
		cmd          = '0;
		sample_ready = (state_q == S_IDLE);
		cmd.accept   = sample_valid && sample_ready;
		cmd.emit_step   = step_q;
		cmd.emit_single = single_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.accept) state_d = S_START_B;
			end
			S_START_B: begin
				if (sts.kind && sts.jump) begin
					state_d = S_IDLE;
				end else begin
					cmd.scale_start = 1'b1;
					state_d = S_WAIT_B;
				end
			end
			S_WAIT_B: begin
				if (sts.scale_done) begin
					cmd.store_b = 1'b1;
					step_d      = PT_M;
					if (!sts.kind) begin
						single_d = 1'b1;
						state_d  = S_EMIT;
					end else begin
						single_d = 1'b0;
						state_d  = S_START_A;
					end
				end
			end
			S_START_A: begin
				cmd.scale_start = 1'b1;
				cmd.scale_prev  = 1'b1;
				state_d = S_WAIT_A;
			end
			S_WAIT_A: begin
				cmd.scale_prev = 1'b1;
				if (sts.scale_done) begin
					cmd.store_a = 1'b1;
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit_load = 1'b1;
					if (single_q || step_q == PT_M6)
						state_d = S_IDLE;
					else
						step_d = step_q + 1'b1;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= PT_M;
			single_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			step_q   <= step_d;
			single_q <= single_d;
		end
	end

endmodule

FILE: rtl/core/touch_stroke_calibrate_interpolate_top.sv
// Top level: touch sample calibration with stroke midpoint interpolation.
// A pen-down sample gives one point; a follow-on sample inside the jitter window
//   gives a stroke of 7 points, and a follow-on sample outside it gives none.
// A new sample beat is taken only once the controller is back to idle after the
//   previous sample; each scaling lane runs a 12-step divide.
// Reset: arst_n clears control state and loads registers with their reset values.
module touch_stroke_calibrate_interpolate_top (
	input  logic                        clk,
	input  logic                        arst_n,
	// sample channel
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  tsci_pkg::in_beat_t          sample,
	// point channel
	output logic                        point_valid,
	input  logic                        point_ready,
	output tsci_pkg::out_beat_t         point,
	// register write port
	input  logic                        wr_en,
	input  logic [tsci_pkg::IDX_W-1:0]  wr_index,
	input  logic [tsci_pkg::REG_W-1:0]  wr_data
);
	import tsci_pkg::*;

	// Controller and datapath talk only through cmd and sts.
	// Each sample is scaled per axis as (raw-min)*size/(max-min): one multiply,
	// then a 12-step restoring divide with overflow check, in two lanes (x, y)
	// that run side by side. The previous sample is scaled by the same lanes
	// afterwards, only when a follow-on sample stays inside the jitter window.
	// Points leave through a single output register, so the next sample beat
	// can be taken while the last point still waits on point_ready.
	cmd_t cmd;
	sts_t sts;

	tsci_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	tsci_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample      (sample),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.cmd         (cmd),
		.sts         (sts),
		.point_valid (point_valid),
		.point_ready (point_ready),
		.point       (point)
	);

endmodule

FILE: rtl/core/tsci_checker.sv
// Port-level checker for the touch stroke block, bound to the top level.
module tsci_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	input  logic                        sample_ready,
	input  tsci_pkg::in_beat_t          sample,
	input  logic                        point_valid,
	input  logic                        point_ready,
	input  tsci_pkg::out_beat_t         point,
	input  logic                        wr_en,
	input  logic [tsci_pkg::IDX_W-1:0]  wr_index,
	input  logic [tsci_pkg::REG_W-1:0]  wr_data
);
	import tsci_pkg::*;

	// one sample at a time: busy right after a beat is taken
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample taken while previous one in work");

	// a stroke is still being emitted while a non-final point waits
	a_stroke_open: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point.last |-> !sample_ready)
		else $error("ready for samples mid-stroke");

	// while idle, no new point appears once the held one is taken
	a_idle_no_point: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready && point_valid && point_ready |=> !point_valid)
		else $error("point emitted while idle");

	// a stalled point holds
	a_point_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && !point_ready |=> point_valid && $stable(point))
		else $error("stalled point changed");

endmodule

bind touch_stroke_calibrate_interpolate_top tsci_checker u_tsci_checker (.*);

FILE: tb/testbench.sv
// Testbench for the touch stroke calibration block: predicted points checked beat by beat.
module testbench;
	import tsci_pkg::*;

	// sample kinds
	localparam logic KIND_PEN_DOWN = 1'b0;
	localparam logic KIND_FOLLOW   = 1'b1;
	// index past the register list, must be ignored by the block
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int STROKE_POINTS = 7;
	// settle time once the last point is out; a rejected sample shows nothing
	localparam int SETTLE_CYCLES = 60;
	localparam int DRAIN_LIMIT   = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_ready;
	in_beat_t    sample = '0;
	logic        point_valid;
	logic        point_ready = 1'b0;
	out_beat_t   point;
	logic        wr_en = 1'b0;
	logic [IDX_W-1:0] wr_index = '0;
	logic [REG_W-1:0] wr_data = '0;

	// calibration copy kept by the predictor
	logic [RAW_W-1:0]  cal_x_min = RST_X_MIN;
	logic [RAW_W-1:0]  cal_x_max = RST_X_MAX;
	logic [RAW_W-1:0]  cal_y_min = RST_Y_MIN;
	logic [RAW_W-1:0]  cal_y_max = RST_Y_MAX;
	logic [SIZE_W-1:0] cal_width = RST_WIDTH;
	logic [SIZE_W-1:0] cal_height = RST_HEIGHT;
	logic [RAW_W-1:0]  cal_jitter = RST_JITTER;
	// previous raw sample, zero after reset
	logic [RAW_W-1:0]  last_raw_x = '0;
	logic [RAW_W-1:0]  last_raw_y = '0;

	logic [REG_W-1:0] reg_plan [8];
	out_beat_t points_due [$];
	int  mismatches = 0;
	int  tx_gap = 1;          // non-zero means sample_valid is already low
	bit  tx_quiet = 1'b0;     // stretches with back-to-back beats
	bit  rx_quiet = 1'b0;

	touch_stroke_calibrate_interpolate_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	always #6 clk = ~clk;

	// hard stop, several times the slowest legal run
	initial begin
		#4000000;
		$display("FAILURE");
		$finish;
	end

	function automatic int idle_cycles(input bit quiet);
		return quiet ? 0 : int'($urandom_range(0, 11));
	endfunction

	function automatic int clamp_raw(input int v);
		return (v < 0) ? 0 : (v > 1023) ? 1023 : v;
	endfunction

	// (raw - lo) * size / (hi - lo), truncated toward zero and saturated;
	// an empty or inverted span gives 0
	function automatic int calibrate_axis(input logic [RAW_W-1:0] raw,
			input logic [RAW_W-1:0] lo, input logic [RAW_W-1:0] hi,
			input logic [SIZE_W-1:0] size);
		int num;
		int den;
		int v;
		if (hi <= lo)
			return 0;
		num = (int'(raw) - int'(lo)) * int'(size);
		den = int'(hi) - int'(lo);
		v = num / den;
		if (v > int'(SAT_MAX))
			v = int'(SAT_MAX);
		if (v < int'(SAT_MIN))
			v = int'(SAT_MIN);
		return v;
	endfunction

	// halving with truncation toward zero, so odd negative sums round up
	function automatic int midpoint(input int a, input int b);
		return (a + b) / 2;
	endfunction

	// queue the points one accepted sample must produce, and move the
	// previous-sample state on whatever happens
	function automatic void predict_points(input in_beat_t s);
		logic [RAW_W-1:0] ox;
		logic [RAW_W-1:0] oy;
		int ax, ay, bx, by, dx, dy;
		int px [STROKE_POINTS];
		int py [STROKE_POINTS];
		out_beat_t p;
		ox = last_raw_x;
		oy = last_raw_y;
		last_raw_x = s.raw_x;
		last_raw_y = s.raw_y;
		bx = calibrate_axis(s.raw_x, cal_x_min, cal_x_max, cal_width);
		by = calibrate_axis(s.raw_y, cal_y_min, cal_y_max, cal_height);
		if (s.kind == KIND_PEN_DOWN) begin
			p.screen_x = COORD_W'(bx);
			p.screen_y = COORD_W'(by);
			p.last = 1'b1;
			points_due.push_back(p);
			return;
		end
		dx = int'(s.raw_x) - int'(ox);
		dy = int'(s.raw_y) - int'(oy);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		// jumped too far: stored, but no points
		if (dx > int'(cal_jitter) || dy > int'(cal_jitter))
			return;
		ax = calibrate_axis(ox, cal_x_min, cal_x_max, cal_width);
		ay = calibrate_axis(oy, cal_y_min, cal_y_max, cal_height);
		// m, m1 .. m6 in emission order
		px[0] = midpoint(bx, ax);     py[0] = midpoint(by, ay);
		px[1] = midpoint(px[0], ax);  py[1] = midpoint(py[0], ay);
		px[2] = midpoint(px[0], bx);  py[2] = midpoint(py[0], by);
		px[3] = midpoint(ax, px[1]);  py[3] = midpoint(ay, py[1]);
		px[4] = midpoint(px[0], px[1]); py[4] = midpoint(py[0], py[1]);
		px[5] = midpoint(px[0], px[2]); py[5] = midpoint(py[0], py[2]);
		px[6] = midpoint(px[2], bx);  py[6] = midpoint(py[2], by);
		for (int k = 0; k < STROKE_POINTS; k++) begin
			p.screen_x = COORD_W'(px[k]);
			p.screen_y = COORD_W'(py[k]);
			p.last = (k == STROKE_POINTS - 1);
			points_due.push_back(p);
		end
	endfunction

	function automatic void plan_regs(input int x_min, input int x_max, input int y_min,
			input int y_max, input int width, input int height, input int jitter);
		reg_plan[REG_X_MIN]  = REG_W'(x_min);
		reg_plan[REG_X_MAX]  = REG_W'(x_max);
		reg_plan[REG_Y_MIN]  = REG_W'(y_min);
		reg_plan[REG_Y_MAX]  = REG_W'(y_max);
		reg_plan[REG_WIDTH]  = REG_W'(width);
		reg_plan[REG_HEIGHT] = REG_W'(height);
		reg_plan[REG_JITTER] = REG_W'(jitter);
		reg_plan[REG_UNUSED] = REG_W'($urandom_range(0, 2047));
	endfunction

	// one beat on the sample channel; valid stays up into the next beat
	// only when that beat follows with no gap
	task automatic send_sample(input logic kind, input int x, input int y);
		in_beat_t s;
		s.kind = kind;
		s.raw_x = RAW_W'(x);
		s.raw_y = RAW_W'(y);
		if (tx_gap != 0)
			repeat (tx_gap) @(posedge clk);
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		predict_points(s);
		if ($urandom_range(0, 23) == 0)
			tx_quiet = !tx_quiet;
		tx_gap = idle_cycles(tx_quiet);
		if (tx_gap != 0)
			sample_valid <= 1'b0;
	endtask

	// stop sending, wait for every point due, then let a rejected sample settle
	task automatic drain();
		int waited;
		waited = 0;
		if (tx_gap == 0) begin
			sample_valid <= 1'b0;
			tx_gap = 1;
		end
		while (points_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (points_due.size() != 0) begin
			$display("%0t: %0d points never arrived", $time, points_due.size());
			mismatches++;
			points_due.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// burst of writes through the whole index range, unused index included
	task automatic write_regs();
		logic [IDX_W-1:0] idx;
		logic [REG_W-1:0] val;
		for (int i = 0; i <= int'(REG_UNUSED); i++) begin
			idx = IDX_W'(i);
			val = reg_plan[idx];
			wr_en <= 1'b1;
			wr_index <= idx;
			wr_data <= val;
			@(posedge clk);
			// registers take the low bits of the data
			case (idx)
				REG_X_MIN:  cal_x_min = val[RAW_W-1:0];
				REG_X_MAX:  cal_x_max = val[RAW_W-1:0];
				REG_Y_MIN:  cal_y_min = val[RAW_W-1:0];
				REG_Y_MAX:  cal_y_max = val[RAW_W-1:0];
				REG_WIDTH:  cal_width = val[SIZE_W-1:0];
				REG_HEIGHT: cal_height = val[SIZE_W-1:0];
				REG_JITTER: cal_jitter = val[RAW_W-1:0];
				default: ;
			endcase
		end
		wr_en <= 1'b0;
	endtask

	// reset calibration: stroke from the cleared previous sample, the raw
	// extremes, negative scaling and the jitter window edge on each axis
	task automatic test_reset_calibration();
		send_sample(KIND_FOLLOW, 3, 2);
		send_sample(KIND_PEN_DOWN, 0, 0);
		send_sample(KIND_PEN_DOWN, 1023, 1023);
		send_sample(KIND_PEN_DOWN, 190, 345);
		send_sample(KIND_PEN_DOWN, 850, 690);
		send_sample(KIND_FOLLOW, 847, 694);
		send_sample(KIND_FOLLOW, 852, 699);
		send_sample(KIND_FOLLOW, 858, 699);
		send_sample(KIND_FOLLOW, 858, 705);
	endtask

	// one-count spans with full size: both saturation limits, largest jitter
	task automatic test_saturation();
		drain();
		plan_regs(0, 1, 1022, 1023, 2047, 2047, 1023);
		write_regs();
		send_sample(KIND_PEN_DOWN, 1023, 0);
		send_sample(KIND_FOLLOW, 0, 1023);
		send_sample(KIND_FOLLOW, 1, 1022);
		send_sample(KIND_PEN_DOWN, 1, 1023);
	endtask

	// empty span on x, zero jitter; then zero width and an inverted y span.
	// Upper data bits set on some writes must be dropped.
	task automatic test_degenerate_spans();
		drain();
		plan_regs(500 + 1024, 500, 0, 1023, 480, 2047, 1024);
		write_regs();
		send_sample(KIND_PEN_DOWN, 10, 600);
		send_sample(KIND_FOLLOW, 10, 600);
		send_sample(KIND_FOLLOW, 11, 600);
		send_sample(KIND_FOLLOW, 11, 601);
		drain();
		plan_regs(0, 1023, 900, 100, 0, 1, 1023);
		write_regs();
		send_sample(KIND_PEN_DOWN, 1023, 1023);
		send_sample(KIND_FOLLOW, 0, 0);
	endtask

	// strokes under several calibrations: a pen-down, then follow-ons that
	// mostly wander inside the window, with jumps, edge steps and stray pen-downs
	task automatic test_random_strokes();
		int sent, moves, pick, lim, nx, ny, lo, hi;
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			if (phase % 3 == 2) begin
				plan_regs($urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047));
			end else begin
				lo = $urandom_range(0, 700);
				hi = $urandom_range(lo + 1, 1023);
				nx = $urandom_range(0, 700);
				ny = $urandom_range(nx + 1, 1023);
				lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
					$urandom_range(0, 24);
				plan_regs(lo, hi, nx, ny, $urandom_range(1, 2047),
					$urandom_range(1, 2047), lim);
			end
			write_regs();
			sent = 0;
			while (sent < 55) begin
				nx = $urandom_range(0, 1023);
				ny = $urandom_range(0, 1023);
				send_sample(KIND_PEN_DOWN, nx, ny);
				sent++;
				moves = $urandom_range(2, 10);
				lim = int'(cal_jitter);
				repeat (moves) begin
					pick = $urandom_range(0, 15);
					case (pick)
						0: begin
							nx = $urandom_range(0, 1023);
							ny = $urandom_range(0, 1023);
						end
						1: nx = clamp_raw(nx + lim + 1);
						2: ny = clamp_raw(ny - lim - 1);
						default: begin
							nx = clamp_raw(nx + int'($urandom_range(0, 2 * lim)) - lim);
							ny = clamp_raw(ny + int'($urandom_range(0, 2 * lim)) - lim);
						end
					endcase
					send_sample((pick == 3) ? KIND_PEN_DOWN : KIND_FOLLOW, nx, ny);
					sent++;
				end
			end
		end
	endtask

	// point receiver: random stalls, each beat checked against the oldest
	// point due
	initial begin
		int stall;
		out_beat_t want;
		@(posedge arst_n);
		forever begin
			stall = idle_cycles(rx_quiet);
			if (stall != 0) begin
				point_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			point_ready <= 1'b1;
			do @(posedge clk); while (!point_valid);
			if (points_due.size() == 0) begin
				$display("%0t: unexpected point x %0d y %0d last %0b", $time,
					point.screen_x, point.screen_y, point.last);
				mismatches++;
			end else begin
				want = points_due.pop_front();
				if (point !== want) begin
					$display("%0t: expected x %0d y %0d last %0b, got x %0d y %0d last %0b",
						$time, want.screen_x, want.screen_y, want.last,
						point.screen_x, point.screen_y, point.last);
					mismatches++;
				end
			end
			if ($urandom_range(0, 19) == 0)
				rx_quiet = !rx_quiet;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_calibration();
		test_saturation();
		test_degenerate_spans();
		test_random_strokes();
		drain();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

FILE: touch_stroke_calibrate_interpolate_top.f
rtl/core/tsci_pkg.sv
rtl/core/tsci_scale.sv
rtl/core/tsci_datapath.sv
rtl/core/tsci_ctrl.sv
rtl/core/touch_stroke_calibrate_interpolate_top.sv
rtl/core/tsci_checker.sv
tb/testbench.sv
